// ===== hw/rtl/cron_schedule_matcher_assert.svh =====
// ---------------------------------------------------------------------------
// cron schedule matcher assertion macros
// shared concurrent assertion wrappers, clocked on clk_i; CRSM_ASSERT is off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef CRON_SCHEDULE_MATCHER_ASSERT_SVH
`define CRON_SCHEDULE_MATCHER_ASSERT_SVH

// checked only while out of reset
`define CRSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CRSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/crsm_pkg.sv =====
// ---------------------------------------------------------------------------
// crsm_pkg
// types, constants and calendar helpers of the cron schedule matcher
// ---------------------------------------------------------------------------
package crsm_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned WdayW    = 3;
  localparam int unsigned StampW   = 34;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 60;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  localparam int unsigned MinuteMaskW = 60;
  localparam int unsigned HourMaskW   = 24;
  localparam int unsigned DayMaskW    = 31;
  localparam int unsigned MonthMaskW  = 12;
  localparam int unsigned WdayMaskW   = 7;

  // register indexes on the config port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MINUTE_MASK   = 3'd0,
    CFG_HOUR_MASK     = 3'd1,
    CFG_DAY_MASK      = 3'd2,
    CFG_MONTH_MASK    = 3'd3,
    CFG_WEEKDAY_MASK  = 3'd4,
    CFG_START_STAMP   = 3'd5,
    CFG_START_WEEKDAY = 3'd6,
    CFG_END_STAMP     = 3'd7
  } cfg_idx_e;

  // calendar time, year first so the first five fields form a stamp
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [WdayW-1:0]   weekday;
  } cal_t;

  localparam logic [YearW-1:0]   RstYear    = 14'd1970;
  localparam logic [MonthW-1:0]  RstMonth   = 4'd1;
  localparam logic [DayW-1:0]    RstDay     = 5'd1;
  localparam logic [HourW-1:0]   RstHour    = 5'd0;
  localparam logic [MinuteW-1:0] RstMinute  = 6'd0;
  localparam logic [WdayW-1:0]   RstWeekday = 3'd4;
  localparam logic [StampW-1:0]  RstStamp   = 34'd2065762304;

  localparam logic [MinuteW-1:0] LastMinute  = 6'd59;
  localparam logic [HourW-1:0]   LastHour    = 5'd23;
  localparam logic [MonthW-1:0]  LastMonth   = 4'd12;
  localparam logic [WdayW-1:0]   LastWeekday = 3'd6;
  localparam logic [MonthW-1:0]  MonthFeb    = 4'd2;

  // floor(y / 25) as (y * ceil(2^20 / 25)) >> 20, exact for 14-bit y
  localparam logic [15:0] Recip25 = 16'd41944;

  // gregorian leap year: y % 4 == 0 and (y % 100 != 0 or y % 400 == 0)
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [YearW+15:0] prod;
    logic [9:0]        quot;
    logic [14:0]       quot25;
    logic              div25;
    prod   = {16'd0, year} * {{YearW{1'b0}}, Recip25};
    quot   = prod[29:20];
    quot25 = {1'b0, quot, 4'd0} + {2'd0, quot, 3'd0} + {5'd0, quot};
    div25  = ({1'b0, year} == quot25);
    return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  // month length; bad month codes count as 31 days
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                 input logic              leap);
    logic [DayW-1:0] n;
    unique case (month)
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/cron_schedule_matcher.sv =====
// ---------------------------------------------------------------------------
// cron schedule matcher
// a tick's result is registered and shown on the output in the cycle after the tick is taken
// throughput: one tick per cycle while the result stream applies no back-pressure
// reset: masks clear, start and end go to 1970-01-01 00:00, counter to start
// ---------------------------------------------------------------------------
`include "cron_schedule_matcher_assert.svh"

module cron_schedule_matcher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [crsm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [crsm_pkg::CfgDataW-1:0]  cfg_data_i,
  // tick stream in
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [crsm_pkg::InDataW-1:0]   s_axis_tdata_i,  // [0] restart, [7:1] zero
  // result stream out
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [crsm_pkg::OutDataW-1:0]  m_axis_tdata_o   // [0] fire, [1] past_end,
                                                          // [15:2] cur_year,
                                                          // [19:16] cur_month,
                                                          // [24:20] cur_day,
                                                          // [29:25] cur_hour,
                                                          // [35:30] cur_minute,
                                                          // [38:36] cur_weekday,
                                                          // [39] zero
);
  import crsm_pkg::*;

  // -------------------------------------------------------------------------
  // configuration registers, always ready
  // -------------------------------------------------------------------------
  logic [MinuteMaskW-1:0] minute_mask_q;
  logic [HourMaskW-1:0]   hour_mask_q;
  logic [DayMaskW-1:0]    day_mask_q;
  logic [MonthMaskW-1:0]  month_mask_q;
  logic [WdayMaskW-1:0]   weekday_mask_q;
  logic [StampW-1:0]      start_stamp_q;
  logic [WdayW-1:0]       start_weekday_q;
  logic [StampW-1:0]      end_stamp_q;
  logic                   cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minute_mask_q   <= '0;
      hour_mask_q     <= '0;
      day_mask_q      <= '0;
      month_mask_q    <= '0;
      weekday_mask_q  <= '0;
      start_stamp_q   <= RstStamp;
      start_weekday_q <= RstWeekday;
      end_stamp_q     <= RstStamp;
    end else if (cfg_acc) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MINUTE_MASK:   minute_mask_q   <= cfg_data_i[MinuteMaskW-1:0];
        CFG_HOUR_MASK:     hour_mask_q     <= cfg_data_i[HourMaskW-1:0];
        CFG_DAY_MASK:      day_mask_q      <= cfg_data_i[DayMaskW-1:0];
        CFG_MONTH_MASK:    month_mask_q    <= cfg_data_i[MonthMaskW-1:0];
        CFG_WEEKDAY_MASK:  weekday_mask_q  <= cfg_data_i[WdayMaskW-1:0];
        CFG_START_STAMP:   start_stamp_q   <= cfg_data_i[StampW-1:0];
        CFG_START_WEEKDAY: start_weekday_q <= cfg_data_i[WdayW-1:0];
        CFG_END_STAMP:     end_stamp_q     <= cfg_data_i[StampW-1:0];
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // handshake: the output register decouples the two sides, so a new tick is
  // taken whenever the held result leaves in the same cycle or none is held
  // -------------------------------------------------------------------------
  logic m_valid_q;
  logic s_acc;
  logic restart;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign restart         = s_axis_tdata_i[0];

  // -------------------------------------------------------------------------
  // tested time: a restart beat reloads from the start registers first
  // -------------------------------------------------------------------------
  cal_t cnt_q;
  cal_t cnt_d;
  cal_t start_cal;
  cal_t cur;

  assign start_cal = '{year:    start_stamp_q[33:20],
                       month:   start_stamp_q[19:16],
                       day:     start_stamp_q[15:11],
                       hour:    start_stamp_q[10:6],
                       minute:  start_stamp_q[5:0],
                       weekday: start_weekday_q};
  assign cur = restart ? start_cal : cnt_q;

  // -------------------------------------------------------------------------
  // match: each mask is padded so out-of-range field codes hit a zero bit
  // -------------------------------------------------------------------------
  logic [StampW-1:0] now_stamp;
  logic              before_end;
  logic [63:0]       minute_ext;
  logic [31:0]       hour_ext;
  logic [31:0]       day_ext;
  logic [15:0]       month_ext;
  logic [7:0]        weekday_ext;
  logic              all_match;

  assign now_stamp   = {cur.year, cur.month, cur.day, cur.hour, cur.minute};
  assign before_end  = now_stamp < end_stamp_q;

  assign minute_ext  = {4'd0, minute_mask_q};
  assign hour_ext    = {8'd0, hour_mask_q};
  assign day_ext     = {day_mask_q, 1'b0};       // day 0 never matches
  assign month_ext   = {3'd0, month_mask_q, 1'b0}; // month 0 and 13..15 never match
  assign weekday_ext = {1'b0, weekday_mask_q};

  assign all_match = minute_ext[cur.minute] && hour_ext[cur.hour] &&
                     day_ext[cur.day] && month_ext[cur.month] &&
                     weekday_ext[cur.weekday];

  // -------------------------------------------------------------------------
  // advance one minute; every field wraps at or above its limit
  // -------------------------------------------------------------------------
  logic            leap;
  logic [DayW-1:0] mdays;

  assign leap  = is_leap(cur.year);
  assign mdays = month_days(cur.month, leap);

  always_comb begin
    cnt_d = cur;
    if (cur.minute < LastMinute) begin
      cnt_d.minute = cur.minute + 6'd1;
    end else begin
      cnt_d.minute = '0;
      if (cur.hour < LastHour) begin
        cnt_d.hour = cur.hour + 5'd1;
      end else begin
        // new day: weekday moves along with the date
        cnt_d.hour    = '0;
        cnt_d.weekday = (cur.weekday >= LastWeekday) ? 3'd0 : cur.weekday + 3'd1;
        if (cur.day < mdays) begin
          cnt_d.day = cur.day + 5'd1;
        end else begin
          cnt_d.day = 5'd1;
          if (cur.month < LastMonth) begin
            cnt_d.month = cur.month + 4'd1;
          end else begin
            // year wraps at the top of its 14 bits
            cnt_d.month = 4'd1;
            cnt_d.year  = cur.year + 14'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '{year: RstYear, month: RstMonth, day: RstDay,
                 hour: RstHour, minute: RstMinute, weekday: RstWeekday};
    end else if (s_acc) begin
      cnt_q <= cnt_d;
    end
  end

  // -------------------------------------------------------------------------
  // result register
  // -------------------------------------------------------------------------
  logic       fire_q;
  logic       past_end_q;
  cal_t       out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_acc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      fire_q     <= all_match && before_end;
      past_end_q <= !before_end;
      out_q      <= cur;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.weekday, out_q.minute, out_q.hour, out_q.day,
                            out_q.month, out_q.year, past_end_q, fire_q};

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `CRSM_ASSERT(a_fire_before_end, m_valid_q |-> !(fire_q && past_end_q), "fire with past_end set")
  `CRSM_ASSERT(a_beat_to_result, s_acc |=> m_valid_q, "accepted tick left no result")
  `CRSM_ASSERT(a_minute_step, (s_acc && !restart && (cnt_q.minute < LastMinute)) |=> (cnt_q.minute == $past(cnt_q.minute) + 6'd1), "minute did not step")
  `CRSM_ASSERT(a_restart_load, (s_acc && restart) |=> (out_q.minute == $past(start_stamp_q[5:0])), "restart did not load start minute")

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: cron schedule matcher testbench
// drives minute ticks and register writes into the matcher, keeps its own calendar model,
// checks each beat field by field against a typed-in result, if any, else against it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import crsm_pkg::*;

  localparam int unsigned NumRows     = 35;
  localparam int unsigned RandomTicks = 1450;
  localparam int unsigned StallLimit  = 2000;

  // one result beat, fire in the lowest bit as on m_axis_tdata_o
  typedef struct packed {
    logic [WdayW-1:0]   weekday;
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic               past_end;
    logic               fire;
  } tick_result_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

  // directed row: a register write or a tick, optionally with a typed-in result
  typedef struct {
    row_kind_e      kind;
    cfg_idx_e       reg_idx;
    logic [59:0]    value;
    logic           restart;
    logic           typed;
    tick_result_t   want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i;   // [0] restart, [7:1] zero
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OutDataW-1:0]   m_axis_tdata_o;   // [0] fire, [1] past_end, [15:2] year,
                                           // [19:16] month, [24:20] day, [29:25] hour,
                                           // [35:30] minute, [38:36] weekday, [39] zero

  cron_schedule_matcher i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // local copy of the registers, at their reset values
  logic [MinuteMaskW-1:0] minute_mask = '0;
  logic [HourMaskW-1:0]   hour_mask   = '0;
  logic [DayMaskW-1:0]    day_mask    = '0;
  logic [MonthMaskW-1:0]  month_mask  = '0;
  logic [WdayMaskW-1:0]   wday_mask   = '0;
  logic [StampW-1:0]      start_stamp = RstStamp;
  logic [WdayW-1:0]       start_wday  = RstWeekday;
  logic [StampW-1:0]      end_stamp   = RstStamp;

  // local calendar counter
  logic [YearW-1:0]   cal_year   = RstYear;
  logic [MonthW-1:0]  cal_month  = RstMonth;
  logic [DayW-1:0]    cal_day    = RstDay;
  logic [HourW-1:0]   cal_hour   = RstHour;
  logic [MinuteW-1:0] cal_minute = RstMinute;
  logic [WdayW-1:0]   cal_wday   = RstWeekday;

  tick_result_t pending_results[$];

  int unsigned mismatches    = 0;
  int unsigned ticks_sent    = 0;
  int unsigned restarts_sent = 0;
  int unsigned cfg_writes    = 0;
  int unsigned fires_seen    = 0;
  int unsigned past_end_seen = 0;
  int unsigned beats_taken   = 0;
  int unsigned beats_paced   = 0;
  int unsigned rx_wait       = 0;
  logic        burst_mode    = 1'b0;

  // directed table: reset state, all-ones masks, leap and century rollover,
  // year wrap to 0, out-of-range counter fields, single-bit mask, end boundary
  stim_row_t directed_rows [NumRows] = '{
    // counter right after reset, end equals reset time so already past end
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b1,
      '{fire: 1'b0, past_end: 1'b1, year: 14'd1970, month: 4'd1, day: 5'd1,
        hour: 5'd0, minute: 6'd0, weekday: 3'd4}},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b1,
      '{fire: 1'b0, past_end: 1'b1, year: 14'd1970, month: 4'd1, day: 5'd1,
        hour: 5'd0, minute: 6'd1, weekday: 3'd4}},
    '{ROW_CFG, CFG_MINUTE_MASK, {60{1'b1}}, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_HOUR_MASK, {60{1'b1}}, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_DAY_MASK, {60{1'b1}}, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_MONTH_MASK, {60{1'b1}}, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_WEEKDAY_MASK, {60{1'b1}}, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_END_STAMP, {60{1'b1}}, 1'b0, 1'b0, '0},
    // leap year february end
    '{ROW_CFG, CFG_START_STAMP, {26'd0, 14'd2000, 4'd2, 5'd28, 5'd23, 6'd59},
      1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_START_WEEKDAY, 60'd1, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b1, 1'b1,
      '{fire: 1'b1, past_end: 1'b0, year: 14'd2000, month: 4'd2, day: 5'd28,
        hour: 5'd23, minute: 6'd59, weekday: 3'd1}},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    // century that is not a leap year
    '{ROW_CFG, CFG_START_STAMP, {26'd0, 14'd1900, 4'd2, 5'd28, 5'd23, 6'd59},
      1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    // last minute of the largest year, wraps to year 0
    '{ROW_CFG, CFG_START_STAMP, {26'd0, 14'd16383, 4'd12, 5'd31, 5'd23, 6'd59},
      1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b1, 1'b1,
      '{fire: 1'b1, past_end: 1'b0, year: 14'd16383, month: 4'd12, day: 5'd31,
        hour: 5'd23, minute: 6'd59, weekday: 3'd1}},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    // month, hour, minute and weekday out of range, end at zero
    '{ROW_CFG, CFG_END_STAMP, 60'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_START_STAMP, {26'd0, {34{1'b1}}}, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_START_WEEKDAY, 60'd7, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b1, 1'b1,
      '{fire: 1'b0, past_end: 1'b1, year: 14'd16383, month: 4'd15, day: 5'd31,
        hour: 5'd31, minute: 6'd63, weekday: 3'd7}},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    // month 0 and day 0 never match
    '{ROW_CFG, CFG_END_STAMP, {60{1'b1}}, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_START_STAMP, {26'd0, 14'd2024, 4'd0, 5'd0, 5'd5, 6'd10},
      1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    // only minute 59 matches, end one minute later
    '{ROW_CFG, CFG_MINUTE_MASK, 60'h800_0000_0000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_START_STAMP, {26'd0, 14'd2024, 4'd1, 5'd1, 5'd0, 6'd58},
      1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_END_STAMP, {26'd0, 14'd2024, 4'd1, 5'd1, 5'd1, 6'd0},
      1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_MINUTE_MASK, 60'd0, 1'b0, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // gregorian month length, bad month codes count as 31
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic [YearW-1:0]  y);
    logic leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    case (m)
      MonthFeb:                return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  // result of one tick and the counter advanced by one minute
  function automatic tick_result_t calendar_tick(input logic restart);
    tick_result_t res;
    logic [StampW-1:0] now;
    logic in_window;
    logic hit;
    if (restart) begin
      {cal_year, cal_month, cal_day, cal_hour, cal_minute} = start_stamp;
      cal_wday = start_wday;
    end
    now       = {cal_year, cal_month, cal_day, cal_hour, cal_minute};
    in_window = now < end_stamp;
    // field values with no mask bit never match
    hit = ((cal_minute < 6'd60) ? minute_mask[cal_minute] : 1'b0) &
          ((cal_hour < 5'd24) ? hour_mask[cal_hour] : 1'b0) &
          ((cal_day != 5'd0) ? day_mask[cal_day - 5'd1] : 1'b0) &
          ((cal_month != 4'd0 && cal_month <= LastMonth) ?
            month_mask[cal_month - 4'd1] : 1'b0) &
          ((cal_wday <= LastWeekday) ? wday_mask[cal_wday] : 1'b0);
    res.fire     = hit & in_window;
    res.past_end = ~in_window;
    res.year     = cal_year;
    res.month    = cal_month;
    res.day      = cal_day;
    res.hour     = cal_hour;
    res.minute   = cal_minute;
    res.weekday  = cal_wday;
    // rollover is "at or above the limit" so bad values wrap too
    if (cal_minute < LastMinute) begin
      cal_minute++;
    end else begin
      cal_minute = '0;
      if (cal_hour < LastHour) begin
        cal_hour++;
      end else begin
        cal_hour = '0;
        cal_wday = (cal_wday >= LastWeekday) ? '0 : cal_wday + 3'd1;
        if (cal_day < month_length(cal_month, cal_year)) begin
          cal_day++;
        end else begin
          cal_day = 5'd1;
          if (cal_month < LastMonth) begin
            cal_month++;
          end else begin
            cal_month = 4'd1;
            cal_year++;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void apply_reg(input cfg_idx_e idx, input logic [59:0] value);
    case (idx)
      CFG_MINUTE_MASK:   minute_mask = value[MinuteMaskW-1:0];
      CFG_HOUR_MASK:     hour_mask   = value[HourMaskW-1:0];
      CFG_DAY_MASK:      day_mask    = value[DayMaskW-1:0];
      CFG_MONTH_MASK:    month_mask  = value[MonthMaskW-1:0];
      CFG_WEEKDAY_MASK:  wday_mask   = value[WdayMaskW-1:0];
      CFG_START_STAMP:   start_stamp = value[StampW-1:0];
      CFG_START_WEEKDAY: start_wday  = value[WdayW-1:0];
      CFG_END_STAMP:     end_stamp   = value[StampW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [59:0] rand60();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[59:0];
  endfunction

  // start time biased toward day, month and year rollover
  function automatic logic [StampW-1:0] random_start();
    logic [59:0]        r;
    logic [YearW-1:0]   y;
    logic [MonthW-1:0]  m;
    logic [DayW-1:0]    d;
    logic [DayW-1:0]    len;
    logic [HourW-1:0]   h;
    logic [MinuteW-1:0] mi;
    r = rand60();
    if ($urandom_range(0, 6) == 0) return r[StampW-1:0];
    case ($urandom_range(0, 7))
      0:       y = 14'd0;
      1:       y = 14'd1900;
      2:       y = 14'd2000;
      3:       y = 14'd2100;
      4:       y = 14'd16383;
      5:       y = 14'd2024;
      default: y = 14'($urandom_range(0, 16383));
    endcase
    case ($urandom_range(0, 3))
      0:       m = MonthFeb;
      1:       m = LastMonth;
      default: m = 4'($urandom_range(1, 12));
    endcase
    len = month_length(m, y);
    d   = $urandom_range(0, 1) ? len - 5'($urandom_range(0, 1)) : 5'($urandom_range(1, len));
    h   = $urandom_range(0, 1) ? LastHour : 5'($urandom_range(0, 23));
    mi  = 6'($urandom_range(0, 59));
    return {y, m, d, h, mi};
  endfunction

  // write data for one register, upper bits left random
  function automatic logic [59:0] random_reg_value(input cfg_idx_e idx);
    logic [59:0] v;
    v = rand60();
    case (idx)
      CFG_START_STAMP:   v[StampW-1:0] = random_start();
      CFG_START_WEEKDAY: v[WdayW-1:0] = ($urandom_range(0, 9) == 0) ?
                                        3'd7 : 3'($urandom_range(0, 6));
      CFG_END_STAMP: begin
        case ($urandom_range(0, 4))
          0:       v[StampW-1:0] = '1;
          1:       v[StampW-1:0] = '0;
          2, 3:    v[StampW-1:0] = start_stamp + 34'($urandom_range(0, 300));
          default: ;
        endcase
      end
      default: begin
        // masks: mostly full so the and of all five fires often
        case ($urandom_range(0, 4))
          0, 1:    v = '1;
          2:       v = v & rand60() & rand60();
          3:       v = v | rand60();
          default: ;
        endcase
      end
    endcase
    return v;
  endfunction

  // register write, only once every expected beat is back
  task automatic write_reg(input cfg_idx_e idx, input logic [59:0] value);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one tick beat; typed rows queue their typed-in result, others the model's
  task automatic send_tick(input logic restart, input logic typed, input tick_result_t want);
    int unsigned  gap;
    tick_result_t predicted;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = calendar_tick(restart);
    if (typed) predicted = want;
    pending_results.insert(pending_results.size(), predicted);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // receiver: after each taken beat, hold tready low for a random stall, none in burst mode
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (beats_taken != beats_paced) begin
        beats_paced = beats_taken;
        rx_wait     = burst_mode ? 0 : $urandom_range(0, 7);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin : result_check
    tick_result_t got;
    tick_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[38:0];
      beats_taken++;
      if (got.fire) fires_seen++;
      if (got.past_end) past_end_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("fire", want.fire, got.fire);
        check_field("past_end", want.past_end, got.past_end);
        check_field("cur_year", want.year, got.year);
        check_field("cur_month", want.month, got.month);
        check_field("cur_day", want.day, got.day);
        check_field("cur_hour", want.hour, got.hour);
        check_field("cur_minute", want.minute, got.minute);
        check_field("cur_weekday", want.weekday, got.weekday);
      end
    end
  end

  // watchdog: ends the run after a long stretch with no beat on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_ticks;
    int unsigned run_len;
    logic        restart;
    random_ticks    = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_tick(directed_rows[i].restart, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases: fresh registers, then a run of ticks from a restart
    while (random_ticks < RandomTicks) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < 8; r++) begin
        write_reg(cfg_idx_e'(r), random_reg_value(cfg_idx_e'(r)));
      end
      run_len = $urandom_range(30, 150);
      if (run_len > RandomTicks - random_ticks) run_len = RandomTicks - random_ticks;
      for (int k = 0; k < run_len; k++) begin
        restart = (k == 0) || ($urandom_range(0, 39) == 0);
        send_tick(restart, 1'b0, '0);
        random_ticks++;
      end
    end

    // drain, then wait for any stray beat
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("tb: %0d ticks (%0d restarts), %0d register writes", ticks_sent, restarts_sent,
             cfg_writes);
    $display("tb: %0d firing minutes, %0d minutes at or past the end time", fires_seen,
             past_end_seen);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
